// ===== rtl/core/ucd_pkg.sv =====
`timescale 1ns / 1ps

package ucd_pkg;

  // Window geometry: at most three bytes wait between transactions, plus the new one.
  localparam int unsigned WinDepth = 4;
  localparam int unsigned CntW     = 3;

  localparam logic [20:0] ReplCp   = 21'h00FFFD;
  localparam logic [20:0] Min2     = 21'h000080;
  localparam logic [20:0] Min3     = 21'h000800;
  localparam logic [20:0] Min4     = 21'h010000;
  localparam logic [20:0] MaxCp    = 21'h10FFFF;
  localparam logic [20:0] SurLo    = 21'h00D800;
  localparam logic [20:0] SurHi    = 21'h00DFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        replaced;
    logic        last_of_run;
    logic        text_done;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic step_emits;
    logic step_ends;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/ucd_datapath.sv =====
`timescale 1ns / 1ps

module ucd_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ucd_pkg::cmd_t    cmd_i,
  output ucd_pkg::status_t status_o,
  input  ucd_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ucd_pkg::out_t    out_data_o
);

  logic [7:0]               win_q [ucd_pkg::WinDepth];
  logic [7:0]               win_d [ucd_pkg::WinDepth];
  logic [ucd_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     done_q;
  logic                     out_valid_q;
  ucd_pkg::out_t            out_q;

  logic                     ascii, c2, c3, c4, multi, incomplete, cont_ok, in_range, good;
  logic [ucd_pkg::CntW-1:0] need, adv, rem, next_need;
  logic [ucd_pkg::CntW-1:0] idx;
  logic [20:0]              val;
  logic [7:0]               b0, nb;
  logic                     next_multi, next_emits, emit, ends;

  // Decode the sequence that starts at the front of the window.
  always_comb begin
    b0    = win_q[0];
    ascii = ~b0[7];
    c2    = (b0[7:5] == 3'b110);
    c3    = (b0[7:4] == 4'b1110);
    c4    = (b0[7:3] == 5'b11110);
    multi = c2 | c3 | c4;
    need  = c4 ? 3'd4 : (c3 ? 3'd3 : 3'd2);
    incomplete = multi && (need > cnt_q);

    cont_ok = (win_q[1][7:6] == 2'b10);
    if (c3 || c4) begin
      cont_ok = cont_ok && (win_q[2][7:6] == 2'b10);
    end
    if (c4) begin
      cont_ok = cont_ok && (win_q[3][7:6] == 2'b10);
    end

    if (c4) begin
      val      = {b0[2:0], win_q[1][5:0], win_q[2][5:0], win_q[3][5:0]};
      in_range = (val >= ucd_pkg::Min4) && (val <= ucd_pkg::MaxCp);
    end else if (c3) begin
      val      = {5'd0, b0[3:0], win_q[1][5:0], win_q[2][5:0]};
      in_range = (val >= ucd_pkg::Min3) &&
                 !((val >= ucd_pkg::SurLo) && (val <= ucd_pkg::SurHi));
    end else begin
      val      = {10'd0, b0[4:0], win_q[1][5:0]};
      in_range = (val >= ucd_pkg::Min2);
    end

    good = multi && !incomplete && cont_ok && in_range;
    adv  = good ? need : 3'd1;
    rem  = cnt_q - adv;

    // Look at the byte that will lead next, to tell whether another result follows.
    nb         = win_q[adv[1:0]];
    next_multi = (nb[7:5] == 3'b110) || (nb[7:4] == 4'b1110) || (nb[7:3] == 5'b11110);
    next_need  = (nb[7:3] == 5'b11110) ? 3'd4 : ((nb[7:4] == 4'b1110) ? 3'd3 : 3'd2);
    next_emits = (rem != '0) && (!next_multi || (next_need <= rem) || done_q);

    emit = incomplete ? done_q : 1'b1;
    ends = incomplete || !next_emits;
  end

  // Window update: append on load, drop consumed bytes on a step.
  always_comb begin
    for (int i = 0; i < ucd_pkg::WinDepth; i++) begin
      win_d[i] = win_q[i];
    end
    cnt_d = cnt_q;
    idx   = '0;
    if (cmd_i.load) begin
      win_d[cnt_q[1:0]] = in_data_i.data_byte;
      cnt_d             = cnt_q + 3'd1;
    end else if (cmd_i.step) begin
      if (incomplete) begin
        cnt_d = done_q ? '0 : cnt_q;
      end else begin
        cnt_d = rem;
        for (int i = 0; i < ucd_pkg::WinDepth; i++) begin
          idx = ucd_pkg::CntW'(i) + adv;
          if (idx < 3'(ucd_pkg::WinDepth)) begin
            win_d[i] = win_q[idx[1:0]];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.step && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ucd_pkg::WinDepth; i++) begin
      win_q[i] <= win_d[i];
    end
    if (cmd_i.load) begin
      done_q <= in_data_i.end_of_text;
    end
    if (cmd_i.step && emit) begin
      out_q.code_point  <= ascii ? {13'd0, b0} : (good ? val : ucd_pkg::ReplCp);
      out_q.replaced    <= !(ascii || good);
      out_q.last_of_run <= ends;
      out_q.text_done   <= done_q;
    end
  end

  assign status_o.step_emits = emit;
  assign status_o.step_ends  = ends;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;

endmodule

// ===== rtl/core/ucd_ctrl.sv =====
`timescale 1ns / 1ps

module ucd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ucd_pkg::status_t status_i,
  output ucd_pkg::cmd_t    cmd_o
);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q;
  logic   stall_q;

  always_comb begin
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = in_valid_i;
      end
      StRun: begin
        // A step that gives no result need not wait for the output register.
        cmd_o.step = status_i.out_free || !status_i.step_emits;
      end
      default: begin
        cmd_o.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      stall_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StRun;
            stall_q <= 1'b1;
          end
        end
        StRun: begin
          if (cmd_o.step && status_i.step_ends) begin
            state_q <= StIdle;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= StIdle;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall_o = stall_q;

endmodule

// ===== rtl/core/utf8_to_codepoint_decoder.sv =====
`timescale 1ns / 1ps
// The first result of a byte is registered in the output register by a step after its transaction.
// A byte causes zero to four results, and the output side may stall them;
// the controller handles one byte at a time.
// Each result is one step of the shared decode unit over the front of the window.
// Reset (rst_ni low, asynchronous) empties the window and drops any pending result.

module utf8_to_codepoint_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ucd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ucd_pkg::out_t out_data_o
);

  // The controller takes a byte in, then steps the datapath once per cycle while not stalled.
  // Each step decodes the sequence at the front of the window and either
  // emits a code point (or U+FFFD), or finds the sequence unfinished. An
  // unfinished sequence stays in the window for the next transaction, unless
  // the byte closed the text, in which case one U+FFFD is given and the
  // window is emptied.
  ucd_pkg::cmd_t    cmd;
  ucd_pkg::status_t status;

  ucd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the window, its fill count and the output register.
  // The output register lets a step proceed in the same cycle that the
  // previous result is taken.
  ucd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
